>>> hdl/multiplexed_seven_segment_driver_macros.svh
// Assertion macros shared by the display driver modules.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_DRIVER_MACROS_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_DRIVER_MACROS_SVH

`ifndef SYNTHESIS

// Check that cond holds in the same cycle as trig.
`define MSSD_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("%m: check failed");

// Check that cond holds in the cycle after trig.
`define MSSD_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("%m: check failed");

`else

`define MSSD_ASSERT_NOW(label, clk, rst, trig, cond)
`define MSSD_ASSERT_NEXT(label, clk, rst, trig, cond)

`endif

`endif

>>> hdl/mssd_pkg.sv
// Shared types, codes and constants of the seven-segment display driver.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package mssd_pkg;

   // Display geometry
   localparam int NUM_DIGITS   = 4;
   localparam int SEGMENT_BITS = 8;
   localparam int PAT_W        = 40;
   localparam int NUMBER_W     = 16;
   localparam int RAW_W        = 32;
   localparam int DIGIT_IDX_W  = 2;
   localparam int PHASE_W      = 4;
   localparam int DIGIT_VAL_W  = 4;
   localparam int CSR_ADDR_W   = 2;

   localparam logic [DIGIT_IDX_W-1:0] LAST_DIGIT = DIGIT_IDX_W'(NUM_DIGITS - 1);

   // Refresh phases within one digit: 0..7 shift, then latch, then dwell
   localparam logic [PHASE_W-1:0] PHASE_LAST_SHIFT = PHASE_W'(SEGMENT_BITS - 1);
   localparam logic [PHASE_W-1:0] PHASE_LATCH      = PHASE_W'(SEGMENT_BITS);
   localparam logic [PHASE_W-1:0] PHASE_DWELL      = PHASE_W'(SEGMENT_BITS + 1);

   // Opcodes
   localparam logic [1:0] OP_SET_NUMBER = 2'd0;
   localparam logic [1:0] OP_SET_RAW    = 2'd1;
   localparam logic [1:0] OP_TICK       = 2'd2;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_REFRESH_PERIOD = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SEG_LOW        = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SEG_HIGH       = 2'd2;

   // Reset values
   localparam logic [NUMBER_W-1:0]     RESET_PERIOD   = 16'd4999;
   localparam logic [PAT_W-1:0]        RESET_SEG_LOW  = 40'd660093598144;
   localparam logic [PAT_W-1:0]        RESET_SEG_HIGH = 40'd620639060626;
   localparam logic [SEGMENT_BITS-1:0] BLANK_PATTERN  = 8'hFF;
   localparam logic [NUMBER_W-1:0]     SATURATE_LIMIT = 16'd9999;
   localparam logic [DIGIT_VAL_W-1:0]  DIGIT_NINE     = 4'd9;

   // Command from controller to datapath
   typedef struct packed {
      logic                   load_number;
      logic                   load_raw;
      logic                   tick_inc;
      logic                   tick_clr;
      logic                   conv_step;
      logic [DIGIT_IDX_W-1:0] conv_idx;
      logic                   out_load;
      logic [DIGIT_IDX_W-1:0] digit;
      logic [PHASE_W-1:0]     phase;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic tick_match;
      logic out_free;
   } ctrl_sts_type;

   // m times the decimal place weight of a conversion step (thousands first)
   function automatic logic [NUMBER_W-1:0] place_multiple(
      input logic [DIGIT_IDX_W-1:0] step,
      input int                     m
   );
      logic [NUMBER_W-1:0] res;
      case (step)
         2'd0:    res = NUMBER_W'(m * 1000);
         2'd1:    res = NUMBER_W'(m * 100);
         2'd2:    res = NUMBER_W'(m * 10);
         default: res = NUMBER_W'(m);
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hdl/mssd_ctrl.sv
// Controller of the display driver: sequences set, tick and refresh work.
// Uses mssd_pkg and the assertion macro header; drives the datapath commands.
`default_nettype none
`include "multiplexed_seven_segment_driver_macros.svh"

module mssd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [1:0]            req_opcode,
   input  wire mssd_pkg::ctrl_sts_type sts,
   output mssd_pkg::ctrl_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_CONVERT = 2'd1;
   localparam logic [1:0] ST_REFRESH = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [mssd_pkg::DIGIT_IDX_W-1:0] step_ff, step_in;
   logic [mssd_pkg::DIGIT_IDX_W-1:0] digit_ff, digit_in;
   logic [mssd_pkg::PHASE_W-1:0]     phase_ff, phase_in;
   logic                             accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      digit_in = digit_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.conv_idx = step_ff;
      cmd.digit    = digit_ff;
      cmd.phase    = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  mssd_pkg::OP_SET_NUMBER: begin
                     cmd.load_number = 1'b1;
                     step_in         = '0;
                     state_in        = ST_CONVERT;
                  end
                  mssd_pkg::OP_SET_RAW: begin
                     cmd.load_raw = 1'b1;
                  end
                  mssd_pkg::OP_TICK: begin
                     if (sts.tick_match) begin
                        cmd.tick_clr = 1'b1;
                        digit_in     = '0;
                        phase_in     = '0;
                        state_in     = ST_REFRESH;
                     end else begin
                        cmd.tick_inc = 1'b1;
                     end
                  end
                  default: begin
                     // drop unused opcode
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            cmd.conv_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == mssd_pkg::DIGIT_IDX_W'(3)) begin
               state_in = ST_IDLE;
            end
         end
         ST_REFRESH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (phase_ff == mssd_pkg::PHASE_DWELL) begin
                  phase_in = '0;
                  digit_in = digit_ff + 1'b1;
                  if (digit_ff == mssd_pkg::LAST_DIGIT) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  phase_in = phase_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         digit_ff <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         digit_ff <= digit_in;
         phase_ff <= phase_in;
      end
   end

   `MSSD_ASSERT_NOW(a_load_needs_slot, clock, reset, cmd.out_load, sts.out_free)
   `MSSD_ASSERT_NEXT(a_refresh_starts_clean, clock, reset, accept && req_opcode == mssd_pkg::OP_TICK && sts.tick_match, state_ff == ST_REFRESH && digit_ff == '0 && phase_ff == '0)
   `MSSD_ASSERT_NOW(a_phase_in_range, clock, reset, state_ff == ST_REFRESH, phase_ff <= mssd_pkg::PHASE_DWELL && digit_ff <= mssd_pkg::LAST_DIGIT)

endmodule

`default_nettype wire

>>> hdl/mssd_dpath.sv
// Datapath of the display driver: registers, digit store, decimal
// conversion, tick counter and result register. Uses mssd_pkg and the macros.
`default_nettype none
`include "multiplexed_seven_segment_driver_macros.svh"

module mssd_dpath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [mssd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [mssd_pkg::PAT_W-1:0]         csr_wdata,
   input  wire logic [mssd_pkg::NUMBER_W-1:0]      req_number,
   input  wire logic [mssd_pkg::RAW_W-1:0]         req_raw,
   input  wire mssd_pkg::ctrl_cmd_type             cmd,
   output mssd_pkg::ctrl_sts_type                  sts,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [7:0]                              rsp_tdata,
   output logic                                    rsp_tlast
);

   localparam int SB = mssd_pkg::SEGMENT_BITS;

   logic [mssd_pkg::NUMBER_W-1:0] period_ff;
   logic [mssd_pkg::PAT_W-1:0]    seg_low_ff, seg_high_ff;
   logic [mssd_pkg::NUMBER_W-1:0] tick_ff, tick_in;
   logic [SB-1:0]                 pattern_ff [mssd_pkg::NUM_DIGITS];
   logic [mssd_pkg::NUMBER_W-1:0] rem_ff, rem_in;
   logic                          sat_ff;
   logic                          valid_ff, valid_in;
   logic [7:0]                    data_ff, data_in;
   logic                          last_ff, last_in;

   logic [mssd_pkg::DIGIT_VAL_W-1:0] digit_val;
   logic [mssd_pkg::NUMBER_W-1:0]    sub_val;
   logic [2*mssd_pkg::PAT_W-1:0]     seg_table;
   logic [6:0]                       seg_pos;
   logic [SB-1:0]                    seg_code;
   logic [SB-1:0]                    cur_pat;
   logic                             bit_out;
   logic [3:0]                       enable_n;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= mssd_pkg::RESET_PERIOD;
         seg_low_ff  <= mssd_pkg::RESET_SEG_LOW;
         seg_high_ff <= mssd_pkg::RESET_SEG_HIGH;
      end else if (csr_we) begin
         case (csr_addr)
            mssd_pkg::REG_REFRESH_PERIOD: period_ff <= csr_wdata[mssd_pkg::NUMBER_W-1:0];
            mssd_pkg::REG_SEG_LOW:        seg_low_ff <= csr_wdata;
            mssd_pkg::REG_SEG_HIGH:       seg_high_ff <= csr_wdata;
            default: begin
               // ignore writes beyond the register list
            end
         endcase
      end
   end

   // Tick counter, clear on match
   assign sts.tick_match = (tick_ff == period_ff);

   always_comb begin
      tick_in = tick_ff;
      if (cmd.tick_clr) begin
         tick_in = '0;
      end else if (cmd.tick_inc) begin
         tick_in = tick_ff + 1'b1;
      end
   end

   // One decimal digit per step: largest multiple of the place weight, or nine when saturated
   always_comb begin
      digit_val = '0;
      sub_val   = '0;
      for (int m = 1; m <= 9; m++) begin
         if (rem_ff >= mssd_pkg::place_multiple(cmd.conv_idx, m)) begin
            digit_val = mssd_pkg::DIGIT_VAL_W'(m);
            sub_val   = mssd_pkg::place_multiple(cmd.conv_idx, m);
         end
      end
      if (sat_ff) begin
         digit_val = mssd_pkg::DIGIT_NINE;
      end
      rem_in = rem_ff - sub_val;
   end

   // Map a digit through the segment table
   assign seg_table = {seg_high_ff, seg_low_ff};
   assign seg_pos   = {digit_val, 3'b000};
   assign seg_code  = seg_table[seg_pos +: SB];

   // Conversion remainder, tick count and digit store
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         for (int i = 0; i < mssd_pkg::NUM_DIGITS; i++) begin
            pattern_ff[i] <= mssd_pkg::BLANK_PATTERN;
         end
      end else begin
         tick_ff <= tick_in;
         if (cmd.load_raw) begin
            for (int i = 0; i < mssd_pkg::NUM_DIGITS; i++) begin
               pattern_ff[i] <= req_raw[SB*i +: SB];
            end
         end else if (cmd.conv_step) begin
            pattern_ff[cmd.conv_idx] <= seg_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_number) begin
         rem_ff <= req_number;
         sat_ff <= (req_number >= mssd_pkg::SATURATE_LIMIT);
      end else if (cmd.conv_step) begin
         rem_ff <= rem_in;
      end
   end

   // Build the next pin event from digit and phase
   assign cur_pat = pattern_ff[cmd.digit];

   always_comb begin
      bit_out  = cur_pat[SB-1];
      enable_n = 4'hF;
      last_in  = 1'b0;
      data_in  = '0;
      if (cmd.phase <= mssd_pkg::PHASE_LAST_SHIFT) begin
         bit_out    = cur_pat[cmd.phase[2:0]];
         data_in[1] = 1'b1;
      end else if (cmd.phase == mssd_pkg::PHASE_LATCH) begin
         data_in[2] = 1'b1;
      end else begin
         enable_n = ~(4'b0001 << cmd.digit);
         last_in  = (cmd.digit == mssd_pkg::LAST_DIGIT);
      end
      data_in[0]   = bit_out;
      data_in[6:3] = enable_n;
   end

   // Result register: free when empty or being taken
   assign sts.out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   `MSSD_ASSERT_NEXT(a_tick_clears, clock, reset, cmd.tick_clr, tick_ff == '0)
   `MSSD_ASSERT_NEXT(a_load_shows, clock, reset, cmd.out_load, rsp_tvalid)

endmodule

`default_nettype wire

>>> hdl/multiplexed_seven_segment_driver.sv
// Top level of the multiplexed seven-segment driver.
// Depends on mssd_pkg, mssd_ctrl and mssd_dpath.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser opcode, tdata number, raw
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata pin event, tlast end of run
//  csr     | in        | csr_we                | csr_addr index, csr_wdata value
//
// Set-raw and non-matching tick items finish on acceptance; a set-number item is
// accepted, then runs one shared convert step per decimal digit.
// A matching tick starts a refresh of 40 results, one per cycle while rsp_tready
// holds; the result register stalls the sequencer when the sink backs off.
// The next item is taken in the cycle after the last result is loaded.
// Reset is synchronous: digits blank, tick count zero, registers at defaults.
`default_nettype none

module multiplexed_seven_segment_driver (
   input  wire logic        clock,
   input  wire logic        reset,
   // config write port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [39:0] csr_wdata,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // [15:0] number, [47:16] raw_segments
   input  wire logic [1:0]  req_tuser,  // [1:0] opcode
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // [0] serial_data, [1] shift_pulse,
                                        // [2] latch_pulse, [6:3] digit_enable_n
   output logic             rsp_tlast   // last
);

   mssd_pkg::ctrl_cmd_type cmd;
   mssd_pkg::ctrl_sts_type sts;

   mssd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   mssd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_number (req_tdata[15:0]),
      .req_raw    (req_tdata[47:16]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> test/multiplexed_seven_segment_driver_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multiplexed seven-segment driver.
// Needs mssd_pkg and the driver RTL; a scoreboard class predicts every pin event.

module multiplexed_seven_segment_driver_tb;

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         CYCLE_LIMIT   = 5_000_000;
   localparam int         RANDOM_PHASES = 6;
   localparam int         PHASE_ITEMS   = 68;

   // One pin event of a refresh run
   typedef struct {
      logic       serial_data;
      logic       shift_pulse;
      logic       latch_pulse;
      logic [3:0] digit_enable_n;
      logic       last;
   } pin_event_type;

   // Tracks display state and the pin events still owed by the driver
   class display_scoreboard_type;
      logic [mssd_pkg::NUMBER_W-1:0]     period;
      logic [mssd_pkg::PAT_W-1:0]        table_lo;
      logic [mssd_pkg::PAT_W-1:0]        table_hi;
      logic [mssd_pkg::SEGMENT_BITS-1:0] digit_bytes [mssd_pkg::NUM_DIGITS];
      logic [mssd_pkg::NUMBER_W-1:0]     tick_count;
      pin_event_type                     pin_q [$];
      int                                errors;

      function new();
         period     = mssd_pkg::RESET_PERIOD;
         table_lo   = mssd_pkg::RESET_SEG_LOW;
         table_hi   = mssd_pkg::RESET_SEG_HIGH;
         tick_count = '0;
         errors     = 0;
         foreach (digit_bytes[i]) digit_bytes[i] = mssd_pkg::BLANK_PATTERN;
      endfunction

      function int pending();
         return pin_q.size();
      endfunction

      function void write_register(logic [mssd_pkg::CSR_ADDR_W-1:0] idx,
                                   logic [mssd_pkg::PAT_W-1:0] val);
         case (idx)
            mssd_pkg::REG_REFRESH_PERIOD: period   = val[mssd_pkg::NUMBER_W-1:0];
            mssd_pkg::REG_SEG_LOW:        table_lo = val;
            mssd_pkg::REG_SEG_HIGH:       table_hi = val;
            default: ;
         endcase
      endfunction

      // Look up the segment byte of one decimal digit
      function logic [mssd_pkg::SEGMENT_BITS-1:0] segment_of(int d);
         if (d < 5) return table_lo[8*d +: 8];
         return table_hi[8*(d-5) +: 8];
      endfunction

      // Apply one accepted transaction and queue the refresh it triggers
      function void note_request(logic [1:0] op, logic [mssd_pkg::NUMBER_W-1:0] num,
                                 logic [mssd_pkg::RAW_W-1:0] raw);
         int            n;
         pin_event_type ev;
         n = num;
         case (op)
            mssd_pkg::OP_SET_NUMBER: begin
               if (num < mssd_pkg::SATURATE_LIMIT) begin
                  digit_bytes[0] = segment_of(n / 1000);
                  digit_bytes[1] = segment_of((n % 1000) / 100);
                  digit_bytes[2] = segment_of((n % 100) / 10);
                  digit_bytes[3] = segment_of(n % 10);
               end else begin
                  foreach (digit_bytes[i]) begin
                     digit_bytes[i] = segment_of(int'(mssd_pkg::DIGIT_NINE));
                  end
               end
            end
            mssd_pkg::OP_SET_RAW: begin
               foreach (digit_bytes[i]) digit_bytes[i] = raw[8*i +: 8];
            end
            mssd_pkg::OP_TICK: begin
               if (tick_count == period) begin
                  tick_count = '0;
                  // Shift eight bits LSB first, latch, then dwell on the digit
                  for (int d = 0; d < mssd_pkg::NUM_DIGITS; d++) begin
                     ev.shift_pulse    = 1'b1;
                     ev.latch_pulse    = 1'b0;
                     ev.digit_enable_n = 4'hF;
                     ev.last           = 1'b0;
                     for (int j = 0; j < mssd_pkg::SEGMENT_BITS; j++) begin
                        ev.serial_data = digit_bytes[d][j];
                        pin_q.push_back(ev);
                     end
                     ev.shift_pulse = 1'b0;
                     ev.latch_pulse = 1'b1;
                     pin_q.push_back(ev);
                     ev.latch_pulse    = 1'b0;
                     ev.digit_enable_n = 4'(~(4'b0001 << d));
                     ev.last           = (d == mssd_pkg::NUM_DIGITS - 1);
                     pin_q.push_back(ev);
                  end
               end else begin
                  tick_count = tick_count + 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [3:0] want, logic [3:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      // Compare one result transaction with the oldest expected event
      function void check_event(logic [7:0] tdata, logic tlast);
         pin_event_type want;
         if (pin_q.size() == 0) begin
            $error("unexpected result: tdata %h tlast %b", tdata, tlast);
            errors++;
            return;
         end
         want = pin_q.pop_front();
         compare_field("serial_data", 4'(want.serial_data), 4'(tdata[0]));
         compare_field("shift_pulse", 4'(want.shift_pulse), 4'(tdata[1]));
         compare_field("latch_pulse", 4'(want.latch_pulse), 4'(tdata[2]));
         compare_field("digit_enable_n", want.digit_enable_n, tdata[6:3]);
         compare_field("last", 4'(want.last), 4'(tlast));
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [39:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   display_scoreboard_type sb;
   bit                     sender_calm = 1'b0;
   bit                     sink_calm   = 1'b0;
   int                     cycle_count = 0;
   logic [15:0]            directed_numbers [7];

   multiplexed_seven_segment_driver i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Check every accepted result transaction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_event(rsp_tdata, rsp_tlast);
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(bit calm_mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_mode || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] pick_number();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 16'($urandom_range(9999, 65535));
      if (roll == 1) return ($urandom_range(0, 1) != 0) ? 16'd9999 : 16'd9998;
      return 16'($urandom_range(0, 9998));
   endfunction

   // Back-pressure the result stream
   initial begin
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         if (!sink_calm) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap(1'b0) + 1) @(posedge clock);
         end
      end
   end

   // Present one request transaction and hold it until accepted
   task automatic send_request(logic [1:0] op, logic [15:0] num, logic [31:0] raw);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {raw, num};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, num, raw);
   endtask

   task automatic write_register(logic [1:0] idx, logic [39:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_register(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait out every owed event, then let the block go idle
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic tick_until_refresh();
      do send_request(mssd_pkg::OP_TICK, 16'($urandom()), $urandom());
      while (sb.pending() == 0);
   endtask

   initial begin
      int          roll;
      logic [1:0]  op;
      logic [39:0] lo_pat;
      logic [39:0] hi_pat;

      sb = new();
      directed_numbers = '{16'd0, 16'd1234, 16'd5678, 16'd9012, 16'd9998, 16'd9999,
                           16'd65535};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: blank display, every decimal digit, saturation, raw extremes
      write_register(mssd_pkg::REG_REFRESH_PERIOD, 40'd0);
      send_request(mssd_pkg::OP_TICK, 16'hFFFF, 32'h0);
      foreach (directed_numbers[i]) begin
         send_request(mssd_pkg::OP_SET_NUMBER, directed_numbers[i], $urandom());
         send_request(mssd_pkg::OP_TICK, 16'($urandom()), $urandom());
      end
      send_request(mssd_pkg::OP_SET_RAW, 16'hFFFF, 32'h0000_0000);
      send_request(mssd_pkg::OP_TICK, 16'h0, 32'hFFFF_FFFF);
      send_request(mssd_pkg::OP_SET_RAW, 16'h0, 32'hFFFF_FFFF);
      send_request(mssd_pkg::OP_TICK, 16'hFFFF, 32'h0);
      send_request(OP_UNUSED, 16'h1234, 32'h89AB_CDEF);
      send_request(mssd_pkg::OP_TICK, 16'($urandom()), $urandom());

      // Steady ticks against a mid-size period, then lower it onto the count
      drain_and_settle();
      write_register(mssd_pkg::REG_REFRESH_PERIOD, 40'd6);
      sender_calm = 1'b1;
      tick_until_refresh();
      repeat (3) send_request(mssd_pkg::OP_TICK, 16'($urandom()), $urandom());
      drain_and_settle();
      write_register(mssd_pkg::REG_REFRESH_PERIOD, 40'd3);
      tick_until_refresh();
      sender_calm = 1'b0;

      // Random phases, each with its own period and segment tables
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_and_settle();
         if (p == 0) begin
            lo_pat = '0;
            hi_pat = '1;
         end else if (p == 1) begin
            lo_pat = '1;
            hi_pat = '0;
         end else begin
            lo_pat = 40'({$urandom(), $urandom()});
            hi_pat = 40'({$urandom(), $urandom()});
         end
         write_register(mssd_pkg::REG_REFRESH_PERIOD, 40'($urandom_range(0, 5)));
         write_register(mssd_pkg::REG_SEG_LOW, lo_pat);
         write_register(mssd_pkg::REG_SEG_HIGH, hi_pat);
         sender_calm = (p == 2);
         sink_calm   = (p == 3);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // Hold off until the display has caught up
            if (k == 30 || $urandom_range(0, 99) < 3) begin
               req_tvalid <= 1'b0;
               do @(posedge clock); while (sb.pending() != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 55) op = mssd_pkg::OP_TICK;
            else if (roll < 78) op = mssd_pkg::OP_SET_NUMBER;
            else if (roll < 95) op = mssd_pkg::OP_SET_RAW;
            else op = OP_UNUSED;
            send_request(op, pick_number(), $urandom());
         end
      end
      sink_calm = 1'b0;

      drain_and_settle();
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
